// ----- sv/irpdt_pkg.sv -----
package irpdt_pkg;

    localparam int CODE_W      = 48;
    localparam int TIME_W      = 16;
    localparam int BITCNT_W    = 6;
    localparam int GAP_W       = 17;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 17;
    localparam int CMD_DEPTH   = 2;
    localparam int RES_DEPTH   = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HEADER_MARK  = 3'd0,
        REG_HEADER_SPACE = 3'd1,
        REG_BIT_MARK     = 3'd2,
        REG_ZERO_SPACE   = 3'd3,
        REG_ONE_SPACE    = 3'd4,
        REG_BIT_COUNT    = 3'd5,
        REG_MSB_FIRST    = 3'd6,
        REG_TRAILER_GAP  = 3'd7
    } t_cfg_reg;

    typedef enum logic {
        OP_TICK  = 1'b0,
        OP_START = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_HDR_MARK  = 3'd1,
        PH_HDR_SPACE = 3'd2,
        PH_BIT_MARK  = 3'd3,
        PH_BIT_SPACE = 3'd4,
        PH_GAP       = 3'd5
    } t_phase;

    typedef struct packed {
        logic              op;
        logic [CODE_W-1:0] frame_code;
    } t_in_item;

    typedef struct packed {
        logic pin_level;
        logic busy_res;
        logic start_accepted;
    } t_out_item;

    typedef struct packed {
        t_op               kind;
        logic [CODE_W-1:0] code;
    } t_cmd;

    typedef struct packed {
        logic [TIME_W-1:0]   header_mark;
        logic [TIME_W-1:0]   header_space;
        logic [TIME_W-1:0]   bit_mark;
        logic [TIME_W-1:0]   zero_space;
        logic [TIME_W-1:0]   one_space;
        logic [BITCNT_W-1:0] frame_bit_count;
        logic                msb_first;
        logic [GAP_W-1:0]    trailer_gap;
    } t_cfg;

    localparam logic [TIME_W-1:0]   RST_HEADER_MARK  = 16'd3360;
    localparam logic [TIME_W-1:0]   RST_HEADER_SPACE = 16'd3360;
    localparam logic [TIME_W-1:0]   RST_BIT_MARK     = 16'd800;
    localparam logic [TIME_W-1:0]   RST_ZERO_SPACE   = 16'd800;
    localparam logic [TIME_W-1:0]   RST_ONE_SPACE    = 16'd2500;
    localparam logic [BITCNT_W-1:0] RST_BIT_COUNT    = 6'd48;
    localparam logic                RST_MSB_FIRST    = 1'b0;
    localparam logic [GAP_W-1:0]    RST_TRAILER_GAP  = 17'd89000;

endpackage

// ----- sv/ir_pulse_distance_transmitter_top.sv -----
// Infrared pulse-distance frame transmitter.
// Requests enter through a queue-style port: a request is taken when push is high
// and full is low. Each request is either a one-microsecond tick or a start carrying
// a code word. Every request yields exactly one result, read from a queue-style port:
// the oldest result sits on o_result while empty is low and leaves when pop is high.
// A start while a frame is running is refused and flagged by start_accepted low.
// Timing and format registers are written through i_cfg_we, i_cfg_idx and
// i_cfg_wdata, and should only be changed while no frame is running.
// A request taken into the command queue is executed by the sequencer, which writes
// its result into the result queue, where it becomes visible. One request per cycle is
// sustained: the command queue and the result queue each hold two entries, and the
// sequencer retires one request per cycle whenever the result queue has room.
// When the result side stalls, the result queue fills, the sequencer stops, then the
// command queue fills and full rises; no request is lost.
// Synchronous reset empties both queues, returns the line to idle and restores
// the default timings of the 48-bit LSB-first format.
module ir_pulse_distance_transmitter_top #(
    parameter int MAX_BITS    = 48,
    parameter int COUNT_WIDTH = 17
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 push,
    output logic                                 full,
    input  irpdt_pkg::t_in_item                  i_item,
    output logic                                 empty,
    input  logic                                 pop,
    output irpdt_pkg::t_out_item                 o_result,
    input  logic                                 i_cfg_we,
    input  logic [irpdt_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [irpdt_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);

    import irpdt_pkg::*;

    t_cfg r_cfg, n_cfg;
    t_cmd w_cmd;
    logic w_cmd_empty;
    logic w_cmd_pop;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_idx))
                REG_HEADER_MARK:  n_cfg.header_mark     = i_cfg_wdata[TIME_W-1:0];
                REG_HEADER_SPACE: n_cfg.header_space    = i_cfg_wdata[TIME_W-1:0];
                REG_BIT_MARK:     n_cfg.bit_mark        = i_cfg_wdata[TIME_W-1:0];
                REG_ZERO_SPACE:   n_cfg.zero_space      = i_cfg_wdata[TIME_W-1:0];
                REG_ONE_SPACE:    n_cfg.one_space       = i_cfg_wdata[TIME_W-1:0];
                REG_BIT_COUNT:    n_cfg.frame_bit_count = i_cfg_wdata[BITCNT_W-1:0];
                REG_MSB_FIRST:    n_cfg.msb_first       = i_cfg_wdata[0];
                REG_TRAILER_GAP:  n_cfg.trailer_gap     = i_cfg_wdata[GAP_W-1:0];
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.header_mark     <= RST_HEADER_MARK;
            r_cfg.header_space    <= RST_HEADER_SPACE;
            r_cfg.bit_mark        <= RST_BIT_MARK;
            r_cfg.zero_space      <= RST_ZERO_SPACE;
            r_cfg.one_space       <= RST_ONE_SPACE;
            r_cfg.frame_bit_count <= RST_BIT_COUNT;
            r_cfg.msb_first       <= RST_MSB_FIRST;
            r_cfg.trailer_gap     <= RST_TRAILER_GAP;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    irpdt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_item      (i_item),
        .o_cmd       (w_cmd),
        .o_cmd_empty (w_cmd_empty),
        .i_cmd_pop   (w_cmd_pop)
    );

    irpdt_back #(
        .MAX_BITS    (MAX_BITS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd       (w_cmd),
        .i_cmd_empty (w_cmd_empty),
        .o_cmd_pop   (w_cmd_pop),
        .o_result    (o_result),
        .o_empty     (empty),
        .i_pop       (pop)
    );

endmodule

// ----- sv/irpdt_fifo.sv -----
module irpdt_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             w_wr;
    logic             w_rd;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_wr) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_rd) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({w_wr, w_rd})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ----- sv/irpdt_front.sv -----
module irpdt_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    output logic                o_full,
    input  irpdt_pkg::t_in_item i_item,
    output irpdt_pkg::t_cmd     o_cmd,
    output logic                o_cmd_empty,
    input  logic                i_cmd_pop
);

    import irpdt_pkg::*;

    t_cmd                w_cmd_in;
    logic [$bits(t_cmd)-1:0] w_rd_data;

    always_comb begin
        w_cmd_in.kind = (i_item.op == 1'b1) ? OP_START : OP_TICK;
        w_cmd_in.code = i_item.frame_code;
    end

    irpdt_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_push),
        .i_data  (w_cmd_in),
        .o_full  (o_full),
        .i_pop   (i_cmd_pop),
        .o_data  (w_rd_data),
        .o_empty (o_cmd_empty)
    );

    assign o_cmd = t_cmd'(w_rd_data);

endmodule

// ----- sv/irpdt_back.sv -----
module irpdt_back #(
    parameter int MAX_BITS    = 48,
    parameter int COUNT_WIDTH = 17
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  irpdt_pkg::t_cfg      i_cfg,
    input  irpdt_pkg::t_cmd      i_cmd,
    input  logic                 i_cmd_empty,
    output logic                 o_cmd_pop,
    output irpdt_pkg::t_out_item o_result,
    output logic                 o_empty,
    input  logic                 i_pop
);

    import irpdt_pkg::*;

    localparam int BP_W  = $clog2(MAX_BITS + 1);
    localparam int IDX_W = $clog2(MAX_BITS);
    localparam int UW    = (BP_W > BITCNT_W) ? BP_W : BITCNT_W;
    localparam int LW    = (COUNT_WIDTH > GAP_W) ? COUNT_WIDTH : GAP_W;

    function automatic logic [COUNT_WIDTH-1:0] f_load(input logic [GAP_W-1:0] v);
        logic [LW-1:0] ext;
        ext = LW'(v);
        if (ext == '0) begin
            return COUNT_WIDTH'(1);
        end else if (ext > LW'({COUNT_WIDTH{1'b1}})) begin
            return '1;
        end else begin
            return COUNT_WIDTH'(ext);
        end
    endfunction

    t_phase                 r_phase, n_phase;
    logic [COUNT_WIDTH-1:0] r_ticks, n_ticks;
    logic [BP_W-1:0]        r_bit_pos, n_bit_pos;
    logic [MAX_BITS-1:0]    r_shift, n_shift;

    logic                   w_exec;
    logic                   w_res_full;
    logic                   w_busy;
    logic                   w_level;
    logic [UW-1:0]          w_fbc;
    logic [UW-1:0]          w_used;
    logic [UW-1:0]          w_bp_ext;
    logic [BP_W-1:0]        w_bp_inc;
    logic [UW-1:0]          w_idx;
    logic                   w_cur_bit;
    t_out_item              w_res;
    logic [$bits(t_out_item)-1:0] w_res_data;

    assign w_exec    = !i_cmd_empty && !w_res_full;
    assign o_cmd_pop = w_exec;

    assign w_busy   = (r_phase != PH_IDLE);
    assign w_level  = (r_phase == PH_HDR_MARK) || (r_phase == PH_BIT_MARK);
    assign w_fbc    = UW'(i_cfg.frame_bit_count);
    assign w_used   = (w_fbc > UW'(MAX_BITS)) ? UW'(MAX_BITS) : w_fbc;
    assign w_bp_ext = UW'(r_bit_pos);
    assign w_bp_inc = r_bit_pos + 1'b1;
    assign w_idx    = i_cfg.msb_first ? (w_used - 1'b1 - w_bp_ext) : w_bp_ext;
    assign w_cur_bit = (w_used != '0) && (w_bp_ext < w_used) ?
                       r_shift[w_idx[IDX_W-1:0]] : 1'b0;

    always_comb begin
        n_phase   = r_phase;
        n_ticks   = r_ticks;
        n_bit_pos = r_bit_pos;
        n_shift   = r_shift;
        if (w_exec) begin
            if (i_cmd.kind == OP_START) begin
                if (!w_busy) begin
                    n_phase   = PH_HDR_MARK;
                    n_shift   = MAX_BITS'(i_cmd.code);
                    n_bit_pos = '0;
                    n_ticks   = f_load(GAP_W'(i_cfg.header_mark));
                end
            end else if (!w_busy) begin
                n_phase = PH_IDLE;
                n_ticks = '0;
            end else if (r_ticks > COUNT_WIDTH'(1)) begin
                n_ticks = r_ticks - 1'b1;
            end else begin
                unique case (r_phase)
                    PH_HDR_MARK: begin
                        n_phase = PH_HDR_SPACE;
                        n_ticks = f_load(GAP_W'(i_cfg.header_space));
                    end
                    PH_HDR_SPACE: begin
                        n_bit_pos = '0;
                        if (w_used != '0) begin
                            n_phase = PH_BIT_MARK;
                            n_ticks = f_load(GAP_W'(i_cfg.bit_mark));
                        end else if (i_cfg.trailer_gap == '0) begin
                            n_phase = PH_IDLE;
                            n_ticks = '0;
                        end else begin
                            n_phase = PH_GAP;
                            n_ticks = f_load(i_cfg.trailer_gap);
                        end
                    end
                    PH_BIT_MARK: begin
                        n_phase = PH_BIT_SPACE;
                        n_ticks = w_cur_bit ? f_load(GAP_W'(i_cfg.one_space)) :
                                              f_load(GAP_W'(i_cfg.zero_space));
                    end
                    PH_BIT_SPACE: begin
                        n_bit_pos = w_bp_inc;
                        if (UW'(w_bp_inc) < w_used) begin
                            n_phase = PH_BIT_MARK;
                            n_ticks = f_load(GAP_W'(i_cfg.bit_mark));
                        end else if (i_cfg.trailer_gap == '0) begin
                            n_phase = PH_IDLE;
                            n_ticks = '0;
                        end else begin
                            n_phase = PH_GAP;
                            n_ticks = f_load(i_cfg.trailer_gap);
                        end
                    end
                    default: begin
                        n_phase = PH_IDLE;
                        n_ticks = '0;
                    end
                endcase
            end
        end
    end

    always_comb begin
        w_res = '0;
        if (i_cmd.kind == OP_START) begin
            w_res.start_accepted = !w_busy;
            w_res.busy_res       = 1'b1;
            w_res.pin_level      = !w_busy || w_level;
        end else if (w_busy) begin
            w_res.pin_level = w_level;
            w_res.busy_res  = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_IDLE;
            r_ticks   <= '0;
            r_bit_pos <= '0;
            r_shift   <= '0;
        end else begin
            r_phase   <= n_phase;
            r_ticks   <= n_ticks;
            r_bit_pos <= n_bit_pos;
            r_shift   <= n_shift;
        end
    end

    irpdt_fifo #(
        .WIDTH ($bits(t_out_item)),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_exec),
        .i_data  (w_res),
        .o_full  (w_res_full),
        .i_pop   (i_pop),
        .o_data  (w_res_data),
        .o_empty (o_empty)
    );

    assign o_result = t_out_item'(w_res_data);

    a_idle_no_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE) |-> (r_ticks == '0))
        else $error("idle phase with a nonzero tick count");

    a_busy_has_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_IDLE) |-> (r_ticks != '0))
        else $error("active phase with an empty tick count");

    a_bit_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        UW'(r_bit_pos) <= UW'(MAX_BITS))
        else $error("bit position beyond the word");

    a_start_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_exec && (i_cmd.kind == OP_START) && (r_phase == PH_IDLE))
        |=> (r_phase == PH_HDR_MARK))
        else $error("accepted start did not enter the header mark");

endmodule

// ----- test/tb_ir_pulse_distance_transmitter_top.sv -----
`timescale 1ns / 100ps

module tb_ir_pulse_distance_transmitter_top;

    import irpdt_pkg::*;

    localparam int MAX_BITS        = 48;
    localparam int COUNT_WIDTH     = 17;
    localparam int CODE_IDX_W      = $clog2(CODE_W);
    localparam int LATENCY         = 4;
    localparam int LONG_HOLD       = 100;
    localparam int STALL_LIMIT     = 2000;
    localparam int RANDOM_REQUESTS = 650;
    localparam int CALM_REQUESTS   = 100;
    localparam int MAX_REPORTS     = 10;

    typedef struct {
        t_in_item  req;
        bit        pinned;
        t_out_item want;
    } t_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  push;
    logic                  full;
    t_in_item              i_item;
    logic                  empty;
    logic                  pop;
    t_out_item             o_result;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    // Shadow copy of the transmitter: registers and frame sequencer.
    t_cfg                  fmt;
    t_phase                ph;
    logic [GAP_W-1:0]      ticks_left;
    int unsigned           bit_pos;
    logic [CODE_W-1:0]     code_word;

    t_out_item             expected_lines[$];
    int                    mismatches;
    int                    requests_sent;
    int                    idle_cycles;
    int                    gap_odds;
    int                    stall_odds;
    bit                    long_hold_req;

    ir_pulse_distance_transmitter_top #(
        .MAX_BITS    (MAX_BITS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [GAP_W-1:0] at_least_one(logic [GAP_W-1:0] v);
        return (v == '0) ? GAP_W'(1) : v;
    endfunction

    function automatic void close_frame();
        if (fmt.trailer_gap == '0) begin
            ph = PH_IDLE;
            ticks_left = '0;
        end else begin
            ph = PH_GAP;
            ticks_left = at_least_one(fmt.trailer_gap);
        end
    endfunction

    function automatic void advance_phase();
        int unsigned n;
        bit one_bit;
        n = (fmt.frame_bit_count > MAX_BITS) ? MAX_BITS : fmt.frame_bit_count;
        case (ph)
            PH_HDR_MARK: begin
                ph = PH_HDR_SPACE;
                ticks_left = at_least_one(GAP_W'(fmt.header_space));
            end
            PH_HDR_SPACE: begin
                bit_pos = 0;
                if (n > 0) begin
                    ph = PH_BIT_MARK;
                    ticks_left = at_least_one(GAP_W'(fmt.bit_mark));
                end else begin
                    close_frame();
                end
            end
            PH_BIT_MARK: begin
                one_bit = 1'b0;
                if (bit_pos < n) begin
                    one_bit = code_word[CODE_IDX_W'(fmt.msb_first ? n - 1 - bit_pos : bit_pos)];
                end
                ph = PH_BIT_SPACE;
                ticks_left = at_least_one(GAP_W'(one_bit ? fmt.one_space : fmt.zero_space));
            end
            PH_BIT_SPACE: begin
                bit_pos++;
                if (bit_pos < n) begin
                    ph = PH_BIT_MARK;
                    ticks_left = at_least_one(GAP_W'(fmt.bit_mark));
                end else begin
                    close_frame();
                end
            end
            default: begin
                ph = PH_IDLE;
                ticks_left = '0;
            end
        endcase
    endfunction

    // Returns the line state reported for one request and moves the shadow sequencer on.
    function automatic t_out_item line_step(t_in_item req);
        t_out_item res;
        res = '0;
        if (req.op == OP_START) begin
            if (ph == PH_IDLE) begin
                ph = PH_HDR_MARK;
                code_word = req.frame_code;
                bit_pos = 0;
                ticks_left = at_least_one(GAP_W'(fmt.header_mark));
                res.start_accepted = 1'b1;
            end
            res.pin_level = (ph == PH_HDR_MARK || ph == PH_BIT_MARK);
            res.busy_res = (ph != PH_IDLE);
            return res;
        end
        if (ph == PH_IDLE) begin
            ticks_left = '0;
            return res;
        end
        res.pin_level = (ph == PH_HDR_MARK || ph == PH_BIT_MARK);
        res.busy_res = 1'b1;
        if (ticks_left <= 1) begin
            advance_phase();
        end else begin
            ticks_left--;
        end
        return res;
    endfunction

    function automatic logic [CODE_W-1:0] random_code();
        int pick;
        pick = $urandom_range(0, 7);
        if (pick == 0) begin
            return '0;
        end
        if (pick == 1) begin
            return '1;
        end
        return CODE_W'({$urandom(), $urandom()});
    endfunction

    function automatic t_in_item make_req(t_op op, logic [CODE_W-1:0] code);
        t_in_item req;
        req.op = op;
        req.frame_code = code;
        return req;
    endfunction

    function automatic t_row row(t_op op, logic [CODE_W-1:0] code, bit pinned = 1'b0,
                                 t_out_item want = '0);
        t_row r;
        r.req = make_req(op, code);
        r.pinned = pinned;
        r.want = want;
        return r;
    endfunction

    function automatic t_cfg random_format();
        t_cfg f;
        int pick;
        f.header_mark = TIME_W'($urandom_range(0, 4));
        f.header_space = TIME_W'($urandom_range(0, 4));
        f.bit_mark = TIME_W'($urandom_range(0, 3));
        f.zero_space = TIME_W'($urandom_range(0, 3));
        f.one_space = TIME_W'($urandom_range(0, 5));
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            f.frame_bit_count = '0;
        end else if (pick == 1) begin
            f.frame_bit_count = BITCNT_W'($urandom_range(40, 63));
        end else begin
            f.frame_bit_count = BITCNT_W'($urandom_range(1, 12));
        end
        f.msb_first = 1'($urandom_range(0, 1));
        f.trailer_gap = GAP_W'($urandom_range(0, 6));
        return f;
    endfunction

    task automatic send_request(t_in_item req, bit pinned = 1'b0, t_out_item want = '0);
        int pause;
        t_out_item predicted;
        if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
            push <= 1'b0;
            pause = $urandom_range(1, 15);
            repeat (pause) @(negedge i_clk);
        end
        push <= 1'b1;
        i_item <= req;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        predicted = line_step(req);
        expected_lines.push_back(pinned ? want : predicted);
        requests_sent++;
        @(negedge i_clk);
    endtask

    task automatic settle();
        push <= 1'b0;
        while (expected_lines.size() != 0) @(negedge i_clk);
        repeat (LATENCY) @(negedge i_clk);
    endtask

    // Writes all eight registers; unused upper bits of the write data carry noise.
    task automatic load_format(t_cfg f);
        t_cfg_reg idx;
        logic [CFG_DATA_W-1:0] word;
        idx = idx.first();
        repeat (idx.num()) begin
            word = CFG_DATA_W'($urandom());
            case (idx)
                REG_HEADER_MARK:  word[TIME_W-1:0] = f.header_mark;
                REG_HEADER_SPACE: word[TIME_W-1:0] = f.header_space;
                REG_BIT_MARK:     word[TIME_W-1:0] = f.bit_mark;
                REG_ZERO_SPACE:   word[TIME_W-1:0] = f.zero_space;
                REG_ONE_SPACE:    word[TIME_W-1:0] = f.one_space;
                REG_BIT_COUNT:    word[BITCNT_W-1:0] = f.frame_bit_count;
                REG_MSB_FIRST:    word[0] = f.msb_first;
                default:          word = f.trailer_gap;
            endcase
            i_cfg_we <= 1'b1;
            i_cfg_idx <= idx;
            i_cfg_wdata <= word;
            @(negedge i_clk);
            idx = idx.next();
        end
        i_cfg_we <= 1'b0;
        fmt = f;
    endtask

    task automatic finish_frame();
        int trailing;
        while (ph != PH_IDLE) begin
            if ($urandom_range(0, 24) == 0) begin
                send_request(make_req(OP_START, random_code()));
            end else begin
                send_request(make_req(OP_TICK, random_code()));
            end
        end
        trailing = $urandom_range(0, 3);
        repeat (trailing) send_request(make_req(OP_TICK, random_code()));
    endtask

    task automatic send_frame(logic [CODE_W-1:0] code);
        send_request(make_req(OP_START, code));
        finish_frame();
    endtask

    initial begin
        int stall_left;
        stall_left = 0;
        pop = 1'b0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                stall_left = LONG_HOLD;
            end else if (stall_left == 0 && stall_odds != 0
                         && $urandom_range(1, stall_odds) == 1) begin
                stall_left = $urandom_range(1, 15);
            end
            if (!i_rst_n || stall_left > 0) begin
                pop <= 1'b0;
                if (stall_left > 0) begin
                    stall_left--;
                end
            end else begin
                pop <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : check_results
        t_out_item want;
        if (i_rst_n && pop && !empty) begin
            if (expected_lines.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("%0t: result with nothing expected: ",
                             "pin=%0b busy=%0b accepted=%0b",
                             $realtime, o_result.pin_level, o_result.busy_res,
                             o_result.start_accepted);
                end
            end else begin
                want = expected_lines.pop_front();
                if (o_result.pin_level !== want.pin_level
                    || o_result.busy_res !== want.busy_res
                    || o_result.start_accepted !== want.start_accepted) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("%0t: expected pin=%0b busy=%0b accepted=%0b, ",
                                 "got pin=%0b busy=%0b accepted=%0b",
                                 $realtime, want.pin_level, want.busy_res, want.start_accepted,
                                 o_result.pin_level, o_result.busy_res,
                                 o_result.start_accepted);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no request or result moved for %0d cycles", $realtime, idle_cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        t_row script[$];
        t_cfg plans[$];
        t_cfg f;
        t_cfg extreme;
        int start_count;
        int frames;
        bit second_hold;

        i_rst_n = 1'b0;
        push = 1'b0;
        i_item = '0;
        i_cfg_we = 1'b0;
        i_cfg_idx = REG_HEADER_MARK;
        i_cfg_wdata = '0;
        mismatches = 0;
        requests_sent = 0;
        idle_cycles = 0;
        gap_odds = 6;
        stall_odds = 8;
        long_hold_req = 1'b0;
        second_hold = 1'b0;
        fmt = '{RST_HEADER_MARK, RST_HEADER_SPACE, RST_BIT_MARK, RST_ZERO_SPACE,
                RST_ONE_SPACE, RST_BIT_COUNT, RST_MSB_FIRST, RST_TRAILER_GAP};
        ph = PH_IDLE;
        ticks_left = '0;
        bit_pos = 0;
        code_word = '0;

        // Reset format with a short header mark first; a start while a frame runs must be refused.
        script.push_back(row(OP_TICK, '0, 1'b1, '{1'b0, 1'b0, 1'b0}));
        script.push_back(row(OP_TICK, '1, 1'b1, '{1'b0, 1'b0, 1'b0}));
        script.push_back(row(OP_START, '1, 1'b1, '{1'b1, 1'b1, 1'b1}));
        script.push_back(row(OP_START, '0, 1'b1, '{1'b1, 1'b1, 1'b0}));
        script.push_back(row(OP_TICK, '0, 1'b1, '{1'b1, 1'b1, 1'b0}));
        script.push_back(row(OP_TICK, 48'h5555_5555_5555));
        script.push_back(row(OP_START, 48'hAAAA_AAAA_AAAA));
        script.push_back(row(OP_TICK, 48'h8000_0000_0001));
        script.push_back(row(OP_START, '1));
        script.push_back(row(OP_TICK, '0));

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // A short header mark keeps the first frame brief; the other registers keep
        // their reset values.
        i_cfg_we <= 1'b1;
        i_cfg_idx <= REG_HEADER_MARK;
        i_cfg_wdata <= CFG_DATA_W'(8);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        fmt.header_mark = TIME_W'(8);

        foreach (script[k]) begin
            send_request(script[k].req, script[k].pinned, script[k].want);
        end

        // Shorten the rest of the running frame by reprogramming during its header mark.
        plans.push_back('{16'd0, 16'd1, 16'd0, 16'd0, 16'd2, 6'd63, 1'b1, 17'd0});
        plans.push_back('{16'd1, 16'd1, 16'd1, 16'd1, 16'd2, 6'd0, 1'b0, 17'd3});
        plans.push_back('{16'd2, 16'd3, 16'd1, 16'd2, 16'd4, 6'd8, 1'b1, 17'd5});
        plans.push_back('{16'd3, 16'd1, 16'd0, 16'd0, 16'd0, 6'd1, 1'b0, 17'd1});
        plans.push_back('{16'd4, 16'd4, 16'd0, 16'd0, 16'd2, 6'd32, 1'b1, 17'd9});
        plans.push_back('{16'd1, 16'd2, 16'd1, 16'd1, 16'd2, 6'd20, 1'b0, 17'd2});

        settle();
        load_format(plans[0]);
        finish_frame();

        foreach (plans[k]) begin
            settle();
            load_format(plans[k]);
            send_frame('0);
            send_frame('1);
        end

        // One frame at the largest bit count, sent highest bit first.
        extreme = '{16'd1, 16'd1, 16'd0, 16'd0, 16'd2, 6'd48, 1'b1, 17'd1};
        settle();
        load_format(extreme);
        send_frame(48'h0000_0000_0001);

        start_count = requests_sent;
        long_hold_req = 1'b1;
        while (requests_sent - start_count < RANDOM_REQUESTS) begin
            f = random_format();
            settle();
            load_format(f);
            if (!second_hold && requests_sent - start_count > RANDOM_REQUESTS / 2) begin
                second_hold = 1'b1;
                long_hold_req = 1'b1;
            end
            frames = $urandom_range(1, 4);
            repeat (frames) send_frame(random_code());
        end

        gap_odds = 0;
        stall_odds = 0;
        settle();
        load_format(random_format());
        start_count = requests_sent;
        while (requests_sent - start_count < CALM_REQUESTS) begin
            send_frame(random_code());
        end

        settle();
        repeat (8) @(negedge i_clk);
        if (mismatches == 0 && expected_lines.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
